// ----- src/sble_pkg.sv -----
// Package for the S-box linear bias engine: widths, register and opcode codes,
// and the command and status structs between controller and datapath.
// No dependencies.
package sble_pkg;

	localparam int MAX_IN_BITS  = 8;
	localparam int MAX_OUT_BITS = 8;

	localparam int IN_W    = MAX_IN_BITS;
	localparam int DEPTH   = 1 << IN_W;
	localparam int ENTRY_W = 8;
	localparam int MASK_W  = 8;
	localparam int CFG_W   = 4;
	localparam int CIDX_W  = 2;
	localparam int CNT_W   = IN_W + 1;
	localparam int DIFF_W  = CNT_W + 1;
	localparam int RES_W   = 10;
	localparam int EXT_W   = (DIFF_W > RES_W) ? DIFF_W : RES_W;
	localparam int RES_MAX = 511;
	localparam int RES_MIN = -512;

	localparam logic [CIDX_W-1:0] CFG_IN_BITS     = 2'd0;
	localparam logic [CIDX_W-1:0] CFG_OUT_BITS    = 2'd1;
	localparam logic [CIDX_W-1:0] CFG_REPORT_MODE = 2'd2;

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	localparam logic MODE_BIAS  = 1'b0;
	localparam logic MODE_COUNT = 1'b1;

	typedef struct packed {
		logic load;
		logic start;
		logic rd;
		logic finish;
	} sble_cmd_t;

	typedef struct packed {
		logic last_addr;
		logic out_free;
	} sble_sts_t;

endpackage

// ----- src/sble_if.sv -----
// Channel interfaces of the S-box linear bias engine: input words and result words.
// Depends on sble_pkg for field widths.
interface sble_in_if;
	logic                            valid;
	logic                            ready;
	logic                            opcode;
	logic [sble_pkg::IN_W-1:0]       entry_index;
	logic [sble_pkg::ENTRY_W-1:0]    entry_value;
	logic [sble_pkg::MASK_W-1:0]     alpha_mask;
	logic [sble_pkg::MASK_W-1:0]     beta_mask;

	modport source (output valid, opcode, entry_index, entry_value, alpha_mask, beta_mask,
		input ready);
	modport sink (input valid, opcode, entry_index, entry_value, alpha_mask, beta_mask,
		output ready);
endinterface

interface sble_out_if;
	logic                            valid;
	logic                            ready;
	logic signed [sble_pkg::RES_W-1:0] result_value;
	logic [sble_pkg::MASK_W-1:0]     echo_alpha;
	logic [sble_pkg::MASK_W-1:0]     echo_beta;

	modport source (output valid, result_value, echo_alpha, echo_beta, input ready);
	modport sink (input valid, result_value, echo_alpha, echo_beta, output ready);
endinterface

// ----- src/sbox_linear_bias_engine_unit.sv -----
// S-box linear bias engine: one cell of a linear approximation table per query.
//
// in_ch carries input words: opcode 0 loads entry_value at entry_index into the
// S-box memory, opcode 1 queries the mask pair alpha_mask / beta_mask. out_ch
// carries one result word per query: result_value (bias count - 2^(n-1), or the
// raw agreement count when report_mode is set) with both masks echoed.
// The cfg port writes in_bits (index 0), out_bits (1) and report_mode (2).
//
// A load writes the S-box memory as it is accepted. A query reads the 2^n stored
// entries one per cycle from the synchronous S-box memory, then counts the last read
// word, then writes the result register; the next word is taken only after that.
// The single memory read port sets that pace.
// After reset in_bits and out_bits are 8 and report_mode is 0; S-box entries hold
// no defined value until loaded, and every entry a query reads must be loaded.
// The result register frees the input side: a new word is taken while a result
// waits; a query that finishes while out_ch still stalls holds until it drains.
// Depends on sble_pkg, sble_if, sble_ctrl and sble_dp.
module sbox_linear_bias_engine_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [sble_pkg::CIDX_W-1:0] cfg_index,
	input  logic [sble_pkg::CFG_W-1:0]  cfg_data,
	sble_in_if.sink                     in_ch,
	sble_out_if.source                  out_ch
);
	import sble_pkg::*;

	sble_cmd_t cmd;
	sble_sts_t sts;

	sble_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_opcode (in_ch.opcode),
		.in_ready  (in_ch.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	sble_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.entry_index  (in_ch.entry_index),
		.entry_value  (in_ch.entry_value),
		.alpha_mask   (in_ch.alpha_mask),
		.beta_mask    (in_ch.beta_mask),
		.out_ready    (out_ch.ready),
		.out_valid    (out_ch.valid),
		.result_value (out_ch.result_value),
		.echo_alpha   (out_ch.echo_alpha),
		.echo_beta    (out_ch.echo_beta)
	);

endmodule

// ----- src/sble_ctrl.sv -----
// Controller of the S-box linear bias engine: sequences loads and table walks.
// Depends on sble_pkg for the command and status structs.
module sble_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_opcode,
	output logic                 in_ready,
	input  sble_pkg::sble_sts_t  sts,
	output sble_pkg::sble_cmd_t  cmd
);
	import sble_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_WALK = 2'd1;
	localparam logic [1:0] S_LAST = 2'd2;
	localparam logic [1:0] S_DONE = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       accept;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		unique case (state_q)
			S_IDLE: begin
				if (accept && in_opcode == OP_LOAD) begin
					cmd.load = 1'b1;
				end else if (accept) begin
					cmd.start = 1'b1;
					state_d   = S_WALK;
				end
			end
			S_WALK: begin
				cmd.rd = 1'b1;
				if (sts.last_addr) begin
					state_d = S_LAST;
				end
			end
			// last read word is counted in this cycle
			S_LAST: begin
				state_d = S_DONE;
			end
			S_DONE: begin
				if (sts.out_free) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

`ifndef SYNTH
	a_walk_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WALK && sts.last_addr) |=> (state_q == S_LAST))
		else $error("walk did not end after last address");
	a_last_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_LAST) |=> (state_q == S_DONE))
		else $error("last read not followed by result stage");
	a_finish_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> (state_q == S_IDLE && !$past(cmd.start)))
		else $error("result written without return to idle");
`endif

endmodule

// ----- src/sble_dp.sv -----
// Datapath of the S-box linear bias engine: config registers, S-box memory,
// walk address counter, agreement counter and result register. Depends on sble_pkg.
module sble_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  sble_pkg::sble_cmd_t               cmd,
	output sble_pkg::sble_sts_t               sts,
	input  logic                              cfg_we,
	input  logic [sble_pkg::CIDX_W-1:0]       cfg_index,
	input  logic [sble_pkg::CFG_W-1:0]        cfg_data,
	input  logic [sble_pkg::IN_W-1:0]         entry_index,
	input  logic [sble_pkg::ENTRY_W-1:0]      entry_value,
	input  logic [sble_pkg::MASK_W-1:0]       alpha_mask,
	input  logic [sble_pkg::MASK_W-1:0]       beta_mask,
	input  logic                              out_ready,
	output logic                              out_valid,
	output logic signed [sble_pkg::RES_W-1:0] result_value,
	output logic [sble_pkg::MASK_W-1:0]       echo_alpha,
	output logic [sble_pkg::MASK_W-1:0]       echo_beta
);
	import sble_pkg::*;

	logic [CFG_W-1:0]   in_bits_q;
	logic [CFG_W-1:0]   out_bits_q;
	logic               mode_q;
	logic [CFG_W-1:0]   n_eff;
	logic [CFG_W-1:0]   m_eff;
	logic [ENTRY_W-1:0] mmask;
	logic [IN_W-1:0]    last_x;
	logic [CNT_W-1:0]   half;

	logic [ENTRY_W-1:0] mem_q [DEPTH];
	logic [IN_W-1:0]    addr_q;
	logic [IN_W-1:0]    x_s1;
	logic [ENTRY_W-1:0] data_s1;
	logic               rd_s1;
	logic [IN_W-1:0]    alpha_q;
	logic [ENTRY_W-1:0] beta_q;
	logic [MASK_W-1:0]  alpha_raw_q;
	logic [MASK_W-1:0]  beta_raw_q;
	logic [CNT_W-1:0]   count_q;
	logic               agree;

	logic signed [DIFF_W-1:0] diff;
	logic signed [EXT_W-1:0]  sel;
	logic signed [EXT_W-1:0]  lim_hi;
	logic signed [EXT_W-1:0]  lim_lo;
	logic signed [RES_W-1:0]  res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_bits_q  <= CFG_W'(MAX_IN_BITS);
			out_bits_q <= CFG_W'(MAX_OUT_BITS);
			mode_q     <= MODE_BIAS;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_IN_BITS:     in_bits_q  <= cfg_data;
				CFG_OUT_BITS:    out_bits_q <= cfg_data;
				CFG_REPORT_MODE: mode_q     <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// clamp widths into their legal range
	always_comb begin
		priority if (in_bits_q == '0) n_eff = CFG_W'(1);
		else if (in_bits_q > MAX_IN_BITS) n_eff = CFG_W'(MAX_IN_BITS);
		else n_eff = in_bits_q;
		priority if (out_bits_q == '0) m_eff = CFG_W'(1);
		else if (out_bits_q > MAX_OUT_BITS) m_eff = CFG_W'(MAX_OUT_BITS);
		else m_eff = out_bits_q;
	end

	assign mmask  = ENTRY_W'(((ENTRY_W + 1)'(1) << m_eff) - (ENTRY_W + 1)'(1));
	assign last_x = IN_W'((CNT_W'(1) << n_eff) - CNT_W'(1));
	assign half   = (CNT_W'(1) << n_eff) >> 1;

	assign sts.last_addr = (addr_q == last_x);
	assign sts.out_free  = !out_valid || out_ready;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mem_q[entry_index] <= entry_value;
		end
		data_s1 <= mem_q[addr_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			alpha_q     <= IN_W'(alpha_mask);
			beta_q      <= ENTRY_W'(beta_mask) & mmask;
			alpha_raw_q <= alpha_mask;
			beta_raw_q  <= beta_mask;
		end
		x_s1 <= addr_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q <= '0;
			rd_s1  <= 1'b0;
		end else begin
			rd_s1 <= cmd.rd;
			if (cmd.start) begin
				addr_q <= '0;
			end else if (cmd.rd) begin
				addr_q <= addr_q + IN_W'(1);
			end
		end
	end

	// x stays below 2^n, so alpha needs no further mask here
	assign agree = ~((^(alpha_q & x_s1)) ^ (^(beta_q & data_s1)));

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			count_q <= '0;
		end else if (rd_s1 && agree) begin
			count_q <= count_q + CNT_W'(1);
		end
	end

	assign diff   = $signed({1'b0, count_q}) - $signed({1'b0, half});
	assign sel    = (mode_q == MODE_COUNT) ? EXT_W'($signed({1'b0, count_q})) : EXT_W'(diff);
	assign lim_hi = EXT_W'(RES_MAX);
	assign lim_lo = EXT_W'(RES_MIN);

	always_comb begin
		priority if (sel > lim_hi) res = RES_W'(RES_MAX);
		else if (sel < lim_lo) res = RES_W'(RES_MIN);
		else res = RES_W'(sel);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.finish) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			result_value <= res;
			echo_alpha   <= alpha_raw_q;
			echo_beta    <= beta_raw_q;
		end
	end

endmodule

// ----- sim/sbox_linear_bias_engine_unit_test.sv -----
// Testbench for sbox_linear_bias_engine_unit: loads S-box words, queries mask pairs and
// checks every result word against a linear approximation table predictor kept here.
// Depends on sble_pkg, sble_if and the engine RTL.
module sbox_linear_bias_engine_unit_test;
	import sble_pkg::*;

	localparam logic [CIDX_W-1:0] CFG_UNUSED = 2'd3;

	typedef struct packed {
		logic               op;
		logic [IN_W-1:0]    idx;
		logic [ENTRY_W-1:0] val;
		logic [MASK_W-1:0]  alpha;
		logic [MASK_W-1:0]  beta;
	} sbox_word_t;

	typedef struct packed {
		logic signed [RES_W-1:0] value;
		logic [MASK_W-1:0]       alpha;
		logic [MASK_W-1:0]       beta;
	} lat_cell_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b1;
	logic              cfg_we = 1'b0;
	logic [CIDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]  cfg_data = '0;

	sble_in_if  in_ch ();
	sble_out_if out_ch ();

	sbox_linear_bias_engine_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	always #4 clk = ~clk;

	// predictor state: S-box image and register shadows at their reset values
	logic [ENTRY_W-1:0] sbox_img [DEPTH];
	logic [CFG_W-1:0]   width_in = 4'd8;
	logic [CFG_W-1:0]   width_out = 4'd8;
	logic               report_sel = MODE_BIAS;

	sbox_word_t pending_words [$];
	lat_cell_t  expected_cells [$];
	sbox_word_t cur_word;
	int         send_wait = 0;
	int         recv_wait = 0;
	bit         quiet_run = 1'b0;
	bit         failed = 1'b0;

	function automatic logic signed [RES_W-1:0] lat_cell(input logic [MASK_W-1:0] a,
		input logic [MASK_W-1:0] b);
		int n, m, span, count, res;
		logic [MASK_W-1:0] amask, bmask;
		n = (width_in == 0) ? 1 : ((width_in > MAX_IN_BITS) ? MAX_IN_BITS : width_in);
		m = (width_out == 0) ? 1 : ((width_out > MAX_OUT_BITS) ? MAX_OUT_BITS : width_out);
		span = 1 << n;
		amask = MASK_W'(span - 1);
		bmask = MASK_W'((1 << m) - 1);
		count = 0;
		for (int x = 0; x < span; x++) begin
			if (^(a & amask & MASK_W'(x)) == ^(b & bmask & sbox_img[x]))
				count++;
		end
		res = (report_sel == MODE_BIAS) ? count - (span >> 1) : count;
		if (res > RES_MAX)
			res = RES_MAX;
		if (res < RES_MIN)
			res = RES_MIN;
		return res[RES_W-1:0];
	endfunction

	function automatic int draw_gap();
		return quiet_run ? 0 : $urandom_range(0, 10);
	endfunction

	// sender: a word leaves the queue once the previous one is taken and its gap is over
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.opcode <= OP_LOAD;
			in_ch.entry_index <= '0;
			in_ch.entry_value <= '0;
			in_ch.alpha_mask <= '0;
			in_ch.beta_mask <= '0;
			send_wait = 0;
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				if (cur_word.op == OP_LOAD)
					sbox_img[cur_word.idx] = cur_word.val;
				else
					expected_cells.push_back('{lat_cell(cur_word.alpha, cur_word.beta),
						cur_word.alpha, cur_word.beta});
				send_wait = draw_gap();
			end
			if (!in_ch.valid || in_ch.ready) begin
				if (send_wait > 0) begin
					send_wait--;
					in_ch.valid <= 1'b0;
				end else if (pending_words.size() != 0) begin
					cur_word = pending_words.pop_front();
					in_ch.valid <= 1'b1;
					in_ch.opcode <= cur_word.op;
					in_ch.entry_index <= cur_word.idx;
					in_ch.entry_value <= cur_word.val;
					in_ch.alpha_mask <= cur_word.alpha;
					in_ch.beta_mask <= cur_word.beta;
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	// receiver: compare each result word with the oldest expected cell
	always @(posedge clk or negedge arst_n) begin
		lat_cell_t want;
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			recv_wait = 0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				if (expected_cells.size() == 0) begin
					$display("%0t: unexpected result word value %0d alpha %h beta %h", $time,
						out_ch.result_value, out_ch.echo_alpha, out_ch.echo_beta);
					failed = 1'b1;
				end else begin
					want = expected_cells.pop_front();
					if (out_ch.result_value !== want.value) begin
						$display("%0t: result_value expected %0d got %0d", $time,
							want.value, out_ch.result_value);
						failed = 1'b1;
					end
					if (out_ch.echo_alpha !== want.alpha) begin
						$display("%0t: echo_alpha expected %h got %h", $time,
							want.alpha, out_ch.echo_alpha);
						failed = 1'b1;
					end
					if (out_ch.echo_beta !== want.beta) begin
						$display("%0t: echo_beta expected %h got %h", $time,
							want.beta, out_ch.echo_beta);
						failed = 1'b1;
					end
				end
				recv_wait = draw_gap();
			end
			if (recv_wait > 0) begin
				recv_wait--;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	task automatic push_load(input int idx, input int val);
		pending_words.push_back('{OP_LOAD, IN_W'(idx), ENTRY_W'(val),
			MASK_W'($urandom_range(0, 255)), MASK_W'($urandom_range(0, 255))});
	endtask

	task automatic push_query(input int a, input int b);
		pending_words.push_back('{OP_QUERY, IN_W'($urandom_range(0, 255)),
			ENTRY_W'($urandom_range(0, 255)), MASK_W'(a), MASK_W'(b)});
	endtask

	task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		case (idx)
			CFG_IN_BITS: width_in = data;
			CFG_OUT_BITS: width_out = data;
			CFG_REPORT_MODE: report_sel = data[0];
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// hold until every word is sent and every result is back, then let a load settle;
	// sample on the falling edge so the sender's updates at the rising edge are settled
	task automatic drain();
		do
			@(negedge clk);
		while (pending_words.size() != 0 || in_ch.valid || expected_cells.size() != 0);
		repeat (8) @(posedge clk);
	endtask

	initial begin
		int key, a, n_pick, n_eff, idx;
		arst_n <= 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// fill the whole store with an affine S-box under reset settings: equal masks hit +-128
		key = $urandom_range(0, 255);
		for (int x = 0; x < DEPTH; x++)
			push_load(x, x ^ key);
		push_query(8'h00, 8'h00);
		push_query(8'hFF, 8'hFF);
		push_query(8'h80, 8'h01);
		for (int i = 0; i < 3; i++) begin
			a = $urandom_range(1, 255);
			push_query(a, a);
		end
		push_query($urandom_range(0, 255), $urandom_range(0, 255));
		drain();

		// four-entry S-box in count mode
		write_reg(CFG_IN_BITS, 4'd2);
		write_reg(CFG_REPORT_MODE, 4'd1);
		push_load(0, 8'h00);
		push_load(1, 8'hFF);
		push_load(2, 8'hA5);
		push_load(3, 8'h5A);
		push_query(8'h00, 8'h00);
		push_query(8'hFF, 8'hFF);
		push_query(8'h03, 8'h01);
		push_query(8'h02, 8'h80);
		drain();

		// zero widths act as one bit
		write_reg(CFG_IN_BITS, 4'd0);
		write_reg(CFG_OUT_BITS, 4'd0);
		write_reg(CFG_REPORT_MODE, 4'd0);
		push_query(8'h01, 8'h01);
		push_query(8'hFE, 8'hFE);
		push_query(8'h00, 8'h01);
		drain();

		// oversized widths clamp to eight; the spare register index does nothing
		write_reg(CFG_IN_BITS, 4'd15);
		write_reg(CFG_OUT_BITS, 4'd15);
		write_reg(CFG_UNUSED, 4'd15);
		push_query(8'hFF, 8'h00);
		push_query(8'h55, 8'hAA);
		drain();
		write_reg(CFG_REPORT_MODE, 4'd15);
		push_query(8'h00, 8'h00);
		drain();

		// random phases, small widths favored so stalls overlap short walks
		for (int p = 0; p < 10; p++) begin
			n_pick = $urandom_range(0, 1) ? $urandom_range(1, 3) : $urandom_range(0, 15);
			n_eff = (n_pick == 0) ? 1 : ((n_pick > 8) ? 8 : n_pick);
			quiet_run = ($urandom_range(0, 3) == 0);
			write_reg(CFG_IN_BITS, CFG_W'(n_pick));
			write_reg(CFG_OUT_BITS, CFG_W'($urandom_range(0, 15)));
			write_reg(CFG_REPORT_MODE, CFG_W'($urandom_range(0, 15)));
			for (int i = 0; i < 32; i++) begin
				if ($urandom_range(0, 9) < 3) begin
					idx = $urandom_range(0, 255);
					if ($urandom_range(0, 1))
						idx = idx % (1 << n_eff);
					push_load(idx, $urandom_range(0, 255));
				end else begin
					push_query($urandom_range(0, 255), $urandom_range(0, 255));
				end
			end
			drain();
		end
		quiet_run = 1'b0;

		// watch for stray words past the longest walk
		repeat (300) @(posedge clk);
		if (!failed)
			$display("sbox_linear_bias_engine_unit verification clean");
		else
			$display("sbox_linear_bias_engine_unit verification failed");
		$finish;
	end

	initial begin
		#8000000;
		$display("sbox_linear_bias_engine_unit verification failed");
		$finish;
	end

endmodule
